// ----- sv/sfb_pkg.sv -----
// Shared types, constants and the CRC-8 step for the short frame builder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sfb_pkg;

   // Frame format
   localparam int unsigned MAX_PAYLOAD    = 249;
   localparam int unsigned FRAME_OVERHEAD = 6;
   localparam logic [7:0]  CRC_POLY       = 8'h8C;

   // Configuration registers
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_VALUE = 2'd2;
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hFF;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h0A;
   localparam logic [7:0] INDEX_VALUE_RESET = 8'h00;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH       = 4;
   localparam int unsigned QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Output steps of one command in the back end
   localparam int unsigned STEP_WIDTH = 3;
   localparam logic [STEP_WIDTH-1:0] STEP_SYNC_FIRST  = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_SYNC_SECOND = 3'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_CMD         = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_INDEX       = 3'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_LENGTH      = 3'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_CRC         = 3'd5;

   typedef struct packed {
      logic       mode;
      logic [7:0] cmd_code;
      logic [7:0] payload_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       error_flag;
   } rsp_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] index_value;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_ERROR
   } cmd_kind_type;

   // value: command code or payload byte; length: total frame length;
   // close: this command ends the frame with a CRC byte
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic [7:0]   length;
      logic         close;
   } cmd_type;

   // One byte through the reflected CRC-8, LSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

// ----- sv/sfb_front.sv -----
// Front end: accepts input transactions, checks them against the frame
// state and turns each into one command. Depends on sfb_pkg.
`timescale 1ns / 1ps

module sfb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  sfb_pkg::req_type req,
   output sfb_pkg::cmd_type cmd
);

   logic [7:0] bytes_left_ff;
   logic [7:0] bytes_left_in;

   always_comb begin
      cmd           = '0;
      bytes_left_in = bytes_left_ff;
      if (!req.mode) begin
         if (req.payload_length > 8'(sfb_pkg::MAX_PAYLOAD)) begin
            // reject, leave any open frame alone
            cmd.kind = sfb_pkg::CMD_ERROR;
         end else begin
            cmd.kind      = sfb_pkg::CMD_START;
            cmd.value     = req.cmd_code;
            cmd.length    = req.payload_length + 8'(sfb_pkg::FRAME_OVERHEAD);
            cmd.close     = (req.payload_length == 8'd0);
            bytes_left_in = req.payload_length;
         end
      end else begin
         if (bytes_left_ff == 8'd0) begin
            // no open frame: drop the byte
            cmd.kind = sfb_pkg::CMD_ERROR;
         end else begin
            cmd.kind      = sfb_pkg::CMD_DATA;
            cmd.value     = req.data_byte;
            cmd.close     = (bytes_left_ff == 8'd1);
            bytes_left_in = bytes_left_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// ----- sv/sfb_cmd_queue.sv -----
// Short command queue between the front and back ends.
// Depends on sfb_pkg for the command type and the depth.
`timescale 1ns / 1ps

module sfb_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             enq,
   input  sfb_pkg::cmd_type enq_cmd,
   input  logic             deq,
   output sfb_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   sfb_pkg::cmd_type                        entries_ff [sfb_pkg::QUEUE_DEPTH];
   logic [sfb_pkg::QUEUE_PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sfb_pkg::QUEUE_PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sfb_pkg::QUEUE_COUNT_WIDTH-1:0]   count_ff, count_in;

   assign full  = (count_ff == sfb_pkg::QUEUE_COUNT_WIDTH'(sfb_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entries_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

endmodule

// ----- sv/sfb_back.sv -----
// Back end: expands queued commands into frame bytes, one per cycle while the result
// slot is free or popped, keeps the running CRC and holds the result register. Depends on sfb_pkg.
`timescale 1ns / 1ps

module sfb_back (
   input  logic             clock,
   input  logic             reset,
   input  sfb_pkg::cfg_type cfg,
   input  sfb_pkg::cmd_type head,
   input  logic             queue_empty,
   output logic             deq,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sfb_pkg::rsp_type rsp_data
);

   logic [sfb_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [7:0]                     crc_ff, crc_in;
   logic                           out_valid_ff, out_valid_in;
   sfb_pkg::rsp_type               out_data_ff, res;
   logic                           advance;
   logic                           last_of_cmd;
   logic [7:0]                     hdr_byte;

   assign advance   = !queue_empty && (!out_valid_ff || rsp_pop);
   assign deq       = advance && last_of_cmd;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      case (step_ff)
         sfb_pkg::STEP_SYNC_FIRST:  hdr_byte = cfg.sync_first;
         sfb_pkg::STEP_SYNC_SECOND: hdr_byte = cfg.sync_second;
         sfb_pkg::STEP_CMD:         hdr_byte = head.value;
         sfb_pkg::STEP_INDEX:       hdr_byte = cfg.index_value;
         sfb_pkg::STEP_LENGTH:      hdr_byte = head.length;
         default:                   hdr_byte = crc_ff;
      endcase
   end

   always_comb begin
      res         = '0;
      last_of_cmd = 1'b0;
      crc_in      = crc_ff;
      case (head.kind)
         sfb_pkg::CMD_START: begin
            res.out_byte = hdr_byte;
            if (step_ff == sfb_pkg::STEP_CRC) begin
               res.frame_end = 1'b1;
               res.run_last  = 1'b1;
               last_of_cmd   = 1'b1;
               crc_in        = '0;
            end else begin
               // restart the CRC on the first sync byte
               crc_in = sfb_pkg::crc8_update(
                  (step_ff == sfb_pkg::STEP_SYNC_FIRST) ? 8'd0 : crc_ff, hdr_byte);
               if (step_ff == sfb_pkg::STEP_LENGTH && !head.close) begin
                  res.run_last = 1'b1;
                  last_of_cmd  = 1'b1;
               end
            end
         end
         sfb_pkg::CMD_DATA: begin
            if (step_ff == sfb_pkg::STEP_SYNC_FIRST) begin
               res.out_byte = head.value;
               res.run_last = !head.close;
               last_of_cmd  = !head.close;
               crc_in       = sfb_pkg::crc8_update(crc_ff, head.value);
            end else begin
               res.out_byte  = crc_ff;
               res.frame_end = 1'b1;
               res.run_last  = 1'b1;
               last_of_cmd   = 1'b1;
               crc_in        = '0;
            end
         end
         default: begin
            res.error_flag = 1'b1;
            res.run_last   = 1'b1;
            last_of_cmd    = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         step_in      = last_of_cmd ? '0 : step_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         crc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= res;
      end
   end

endmodule

// ----- sv/short_frame_builder_crc8_top.sv -----
// Top level of the short frame builder with CRC-8: configuration registers,
// front end, command queue and back end. Depends on sfb_pkg and sfb_* modules.
// Path: the first result of a transaction is written into a command queue entry and
// then into the result register before it shows on the result port.
// Throughput: one input per cycle while the four-entry command queue is not full; the back
// end gives one result per cycle while the result slot is free or popped (start 5 or 6, payload 1 or 2, error 1).
// Reset: synchronous, active high; clears frame state, queue, CRC, registers.
`timescale 1ns / 1ps

module short_frame_builder_crc8_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  sfb_pkg::req_type                     req_data,
   output logic                                 empty,
   input  logic                                 pop,
   output sfb_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [sfb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                           csr_wdata
);

   sfb_pkg::cfg_type cfg_ff;
   sfb_pkg::cmd_type front_cmd;
   sfb_pkg::cmd_type queue_head;
   logic             queue_full;
   logic             queue_empty;
   logic             enq;
   logic             deq;

   assign full = queue_full;
   assign enq  = push && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= sfb_pkg::SYNC_FIRST_RESET;
         cfg_ff.sync_second <= sfb_pkg::SYNC_SECOND_RESET;
         cfg_ff.index_value <= sfb_pkg::INDEX_VALUE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sfb_pkg::CSR_SYNC_FIRST:  cfg_ff.sync_first  <= csr_wdata;
            sfb_pkg::CSR_SYNC_SECOND: cfg_ff.sync_second <= csr_wdata;
            sfb_pkg::CSR_INDEX_VALUE: cfg_ff.index_value <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (enq),
      .req    (req_data),
      .cmd    (front_cmd)
   );

   sfb_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .enq     (enq),
      .enq_cmd (front_cmd),
      .deq     (deq),
      .head    (queue_head),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   sfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (queue_head),
      .queue_empty (queue_empty),
      .deq         (deq),
      .rsp_empty   (empty),
      .rsp_pop     (pop),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_deq_needs_entry: assert property (@(posedge clock) disable iff (reset)
      deq |-> !queue_empty)
      else $error("command dequeued from empty queue");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !queue_empty)
      else $error("command queue full and empty at once");

   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.frame_end) |-> (rsp_data.run_last && !rsp_data.error_flag))
      else $error("closing CRC byte not last of its transaction");

   a_error_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.error_flag) |-> (rsp_data.out_byte == 8'd0 && rsp_data.run_last))
      else $error("error result carries data");
`endif

endmodule

// ----- bench/short_frame_builder_crc8_top_test.sv -----
// Self-checking testbench for short_frame_builder_crc8_top: a frame and CRC-8 predictor,
// directed and random stimulus, random stalls on both queue sides.
// Depends on sfb_pkg and the short_frame_builder_crc8_top RTL.
`timescale 1ns / 1ps

module short_frame_builder_crc8_top_test;

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;
   localparam logic [7:0] CRC8_MAXIM_POLY = 8'h8C;
   localparam int RANDOM_ITEMS  = 360;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 2000;

   logic clock = 1'b0;
   logic reset;
   logic push;
   logic full;
   sfb_pkg::req_type req_data;
   logic empty;
   logic pop;
   sfb_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [sfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [7:0] csr_wdata;

   // predictor state and its copy of the registers
   logic [7:0] sync_first_q  = sfb_pkg::SYNC_FIRST_RESET;
   logic [7:0] sync_second_q = sfb_pkg::SYNC_SECOND_RESET;
   logic [7:0] index_value_q = sfb_pkg::INDEX_VALUE_RESET;
   logic [7:0] frame_crc     = 8'h00;
   logic [7:0] payload_left  = 8'h00;
   logic       frame_active  = 1'b0;

   sfb_pkg::rsp_type bytes_due[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int calm_left = 0;
   int items_sent = 0;

   short_frame_builder_crc8_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      repeat (8) begin
         if (v[0]) v = (v >> 1) ^ CRC8_MAXIM_POLY;
         else v = v >> 1;
      end
      return v;
   endfunction

   function automatic void queue_wire_byte(input logic [7:0] b);
      bytes_due.push_back(sfb_pkg::rsp_type'{out_byte: b, frame_end: 1'b0, run_last: 1'b0,
                                             error_flag: 1'b0});
      frame_crc = crc8_maxim_step(frame_crc, b);
   endfunction

   function automatic void queue_frame_crc();
      bytes_due.push_back(sfb_pkg::rsp_type'{out_byte: frame_crc, frame_end: 1'b1,
                                             run_last: 1'b0, error_flag: 1'b0});
      frame_crc = 8'h00;
      frame_active = 1'b0;
   endfunction

   function automatic void encode_item(input sfb_pkg::req_type item);
      sfb_pkg::rsp_type tail;
      if (item.mode == MODE_START && item.payload_length > sfb_pkg::MAX_PAYLOAD) begin
         // rejected start: state stays, an open frame stays open
         bytes_due.push_back(sfb_pkg::rsp_type'{out_byte: 8'h00, frame_end: 1'b0,
                                                run_last: 1'b0, error_flag: 1'b1});
      end else if (item.mode == MODE_START) begin
         frame_crc = 8'h00;
         queue_wire_byte(sync_first_q);
         queue_wire_byte(sync_second_q);
         queue_wire_byte(item.cmd_code);
         queue_wire_byte(index_value_q);
         queue_wire_byte(item.payload_length + 8'(sfb_pkg::FRAME_OVERHEAD));
         payload_left = item.payload_length;
         frame_active = 1'b1;
         if (item.payload_length == 8'h00) queue_frame_crc();
      end else if (!frame_active || payload_left == 8'h00) begin
         // orphan payload byte: dropped and flagged
         bytes_due.push_back(sfb_pkg::rsp_type'{out_byte: 8'h00, frame_end: 1'b0,
                                                run_last: 1'b0, error_flag: 1'b1});
      end else begin
         queue_wire_byte(item.data_byte);
         payload_left = payload_left - 8'h01;
         if (payload_left == 8'h00) queue_frame_crc();
      end
      tail = bytes_due.pop_back();
      tail.run_last = 1'b1;
      bytes_due.push_back(tail);
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         calm_left = $urandom_range(8, 30);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Called and returns at a rising edge; push stays high after the transaction.
   task automatic send_item(input sfb_pkg::req_type item);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      encode_item(item);
      items_sent++;
   endtask

   task automatic send_start(input logic [7:0] cmd, input logic [7:0] len);
      sfb_pkg::req_type item;
      item.mode = MODE_START;
      item.cmd_code = cmd;
      item.payload_length = len;
      item.data_byte = 8'($urandom);
      send_item(item);
   endtask

   task automatic send_payload(input logic [7:0] b);
      sfb_pkg::req_type item;
      item.mode = MODE_PAYLOAD;
      item.cmd_code = 8'($urandom);
      item.payload_length = 8'($urandom);
      item.data_byte = b;
      send_item(item);
   endtask

   // Drop push and wait until every predicted byte has been popped.
   task automatic settle_block();
      push <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on back-to-back edges while the block is idle.
   task automatic load_frame_config(input logic [7:0] first, input logic [7:0] second,
                                    input logic [7:0] index);
      settle_block();
      csr_we <= 1'b1;
      csr_index <= sfb_pkg::CSR_SYNC_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      sync_first_q = first;
      csr_index <= sfb_pkg::CSR_SYNC_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      sync_second_q = second;
      csr_index <= sfb_pkg::CSR_INDEX_VALUE;
      csr_wdata <= index;
      @(posedge clock);
      index_value_q = index;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: runs of steady pop, random pop and long holds.
   initial begin : drive_pop
      int style;
      int run_len;
      pop <= 1'b0;
      forever begin
         style = $urandom_range(0, 9);
         run_len = $urandom_range(4, 40);
         repeat (run_len) begin
            @(posedge clock);
            if (style < 4) pop <= 1'b1;
            else if (style < 8) pop <= ($urandom_range(0, 9) < 7);
            else if (style == 8) pop <= 1'b0;
            else pop <= ($urandom_range(0, 9) < 3);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(negedge clock) begin : check_results
      sfb_pkg::rsp_type due;
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (pop && !empty) begin
            if (bytes_due.size() == 0) begin
               $error("unexpected result: out_byte %0h", rsp_data.out_byte);
               mismatches++;
            end else begin
               due = bytes_due.pop_front();
               if (rsp_data.out_byte !== due.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", due.out_byte, rsp_data.out_byte);
                  mismatches++;
               end
               if (rsp_data.frame_end !== due.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", due.frame_end,
                         rsp_data.frame_end);
                  mismatches++;
               end
               if (rsp_data.run_last !== due.run_last) begin
                  $error("run_last: expected %0b, got %0b", due.run_last, rsp_data.run_last);
                  mismatches++;
               end
               if (rsp_data.error_flag !== due.error_flag) begin
                  $error("error_flag: expected %0b, got %0b", due.error_flag,
                         rsp_data.error_flag);
                  mismatches++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** short_frame_builder_crc8_top: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_config();
      send_start(8'h00, 8'h00);
      send_start(8'hFF, 8'h01);
      send_payload(8'h00);
   endtask

   task automatic test_orphan_payload();
      send_payload(8'hFF);
      send_start(8'h12, 8'h02);
      send_payload(8'hAA);
      send_payload(8'h55);
      send_payload(8'h01);
   endtask

   task automatic test_rejected_length();
      send_start(8'h7E, 8'd250);
      send_start(8'h3C, 8'h03);
      send_payload(8'hC3);
      // rejection keeps the open frame going
      send_start(8'h99, 8'hFF);
      send_payload(8'h0F);
      send_payload(8'hF0);
   endtask

   task automatic test_abandoned_frame();
      send_start(8'h5A, 8'(sfb_pkg::MAX_PAYLOAD));
      send_payload(8'h80);
      send_payload(8'h7F);
      send_start(8'h81, 8'h00);
      send_start(8'h42, 8'h04);
      send_payload(8'h33);
      send_start(8'h24, 8'h01);
      send_payload(8'hE7);
   endtask

   task automatic test_config_extremes();
      load_frame_config(8'h00, 8'h00, 8'h00);
      send_start(8'h01, 8'h00);
      load_frame_config(8'hFF, 8'hFF, 8'hFF);
      send_start(8'hFF, 8'h01);
      send_payload(8'hFF);
      load_frame_config(8'hFF, 8'h0A, 8'hFE);
      send_start(8'h10, 8'h00);
   endtask

   function automatic logic [7:0] pick_csr_value();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic test_random_traffic();
      int start_count;
      int next_cfg;
      int pick;
      int len;
      int n;
      sfb_pkg::req_type item;
      start_count = items_sent;
      next_cfg = 90;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if (items_sent - start_count >= next_cfg) begin
            load_frame_config(pick_csr_value(), pick_csr_value(), pick_csr_value());
            next_cfg += 90;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // well-formed frame; long ones, and some short ones, are cut short by the next start
            len = (pick < 5) ? $urandom_range(7, sfb_pkg::MAX_PAYLOAD) : $urandom_range(0, 6);
            send_start(8'($urandom), 8'(len));
            n = (len > 12) ? $urandom_range(0, 12) : len;
            if (pick >= 68 && len > 0) n = $urandom_range(0, len - 1);
            repeat (n) send_payload(8'($urandom));
         end else if (pick < 85) begin
            send_payload(8'($urandom));
         end else if (pick < 93) begin
            send_start(8'($urandom), 8'($urandom_range(sfb_pkg::MAX_PAYLOAD + 1, 255)));
         end else begin
            item.mode = 1'($urandom);
            item.cmd_code = 8'($urandom);
            item.payload_length = 8'($urandom);
            item.data_byte = 8'($urandom);
            send_item(item);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= sfb_pkg::CSR_SYNC_FIRST;
      csr_wdata <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_orphan_payload();
      test_rejected_length();
      test_abandoned_frame();
      test_config_extremes();
      test_random_traffic();

      settle_block();
      if (mismatches == 0 && bytes_due.size() == 0) begin
         $display("** short_frame_builder_crc8_top: PASSED **");
      end else begin
         $display("** short_frame_builder_crc8_top: FAILED **");
      end
      $finish;
   end

endmodule
